// File: hdl/cmm_pkg.sv
// Shared types and constants for the complex matrix multiply unit.
package cmm_pkg;

    localparam int DIM_W     = 4;
    localparam int DIM_RESET = 4;
    localparam int HALF_W    = 16;
    localparam int ELEM_W    = 2 * HALF_W;
    localparam int ACC_W     = 32;

    typedef struct packed {
        logic vld;
        logic first;
        logic fin;
        logic last;
    } t_ctl;

    typedef enum logic [3:0] {
        S_LOAD  = 4'b0001,
        S_HOLD  = 4'b0010,
        S_ISSUE = 4'b0100,
        S_DRAIN = 4'b1000
    } t_state;

endpackage

// File: hdl/complex_matrix_multiply_unit.sv
// Top level of the complex matrix multiply unit: wiring and result output register.
//
//   channel   direction  handshake               payload
//   config    in         i_cfg_valid/o_cfg_ready i_cfg_dim
//   operand   in         i_valid/o_stall         i_a_re i_a_im i_b_re i_b_im
//   result    out        o_valid/i_stall         o_d_re o_d_im o_last
//
// Loading accepts one beat per cycle unless stalled, n*n beats for side n; a config beat stalls operands.
// Each result is issued as n reads through the single complex MAC, then passes the read,
// product and accumulate registers; the next result is issued once it is done and the output is free.
// Synchronous active-low reset sets side 4 and an empty load.
// A stalled result holds in the output register and blocks the next element.
module complex_matrix_multiply_unit #(
    parameter int MAX_DIM = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [cmm_pkg::DIM_W-1:0]         i_cfg_dim,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [cmm_pkg::HALF_W-1:0] i_a_re,
    input  logic signed [cmm_pkg::HALF_W-1:0] i_a_im,
    input  logic signed [cmm_pkg::HALF_W-1:0] i_b_re,
    input  logic signed [cmm_pkg::HALF_W-1:0] i_b_im,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [cmm_pkg::ACC_W-1:0]  o_d_re,
    output logic signed [cmm_pkg::ACC_W-1:0]  o_d_im,
    output logic                              o_last
);
    import cmm_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic          we;
    logic [AW-1:0] waddr, raddr_a, raddr_b;
    logic [ELEM_W-1:0] rdata_a, rdata_b;
    t_ctl          ctl;
    logic          res_done, res_last;
    logic [ACC_W-1:0] res_re, res_im;
    logic          out_free;

    logic             r_o_valid;
    logic [ACC_W-1:0] r_d_re, r_d_im;
    logic             r_last;

    assign out_free = !r_o_valid || !i_stall;

    cmm_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_dim   (i_cfg_dim),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_raddr_a   (raddr_a),
        .o_raddr_b   (raddr_b),
        .o_ctl       (ctl),
        .i_res_done  (res_done),
        .i_res_last  (res_last),
        .i_out_free  (out_free)
    );

    cmm_store #(.MAX_DIM(MAX_DIM)) u_store (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata_a ({i_a_im, i_a_re}),
        .i_wdata_b ({i_b_im, i_b_re}),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    cmm_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_a     (rdata_a),
        .i_b     (rdata_b),
        .o_done  (res_done),
        .o_last  (res_last),
        .o_re    (res_re),
        .o_im    (res_im)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (res_done) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_done) begin
            r_d_re <= res_re;
            r_d_im <= res_im;
            r_last <= res_last;
        end
    end

    assign o_valid = r_o_valid;
    assign o_d_re  = r_d_re;
    assign o_d_im  = r_d_im;
    assign o_last  = r_last;

endmodule

// File: hdl/cmm_store.sv
// Left and right operand memories, one write port and one registered read port each.
module cmm_store #(
    parameter int MAX_DIM = 8,
    localparam int DEPTH = MAX_DIM * MAX_DIM,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [cmm_pkg::ELEM_W-1:0]  i_wdata_a,
    input  logic [cmm_pkg::ELEM_W-1:0]  i_wdata_b,
    input  logic [AW-1:0]               i_raddr_a,
    input  logic [AW-1:0]               i_raddr_b,
    output logic [cmm_pkg::ELEM_W-1:0]  o_rdata_a,
    output logic [cmm_pkg::ELEM_W-1:0]  o_rdata_b
);
    import cmm_pkg::*;

    logic [ELEM_W-1:0] r_mem_a [DEPTH];
    logic [ELEM_W-1:0] r_mem_b [DEPTH];
    logic [ELEM_W-1:0] r_rdata_a;
    logic [ELEM_W-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem_a[i_waddr] <= i_wdata_a;
            r_mem_b[i_waddr] <= i_wdata_b;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata_a <= r_mem_a[i_raddr_a];
        r_rdata_b <= r_mem_b[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// File: hdl/cmm_mac.sv
// Shared complex multiply-accumulate unit: product stage then wrapping accumulator.
module cmm_mac (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cmm_pkg::t_ctl               i_ctl,
    input  logic [cmm_pkg::ELEM_W-1:0]  i_a,
    input  logic [cmm_pkg::ELEM_W-1:0]  i_b,
    output logic                        o_done,
    output logic                        o_last,
    output logic [cmm_pkg::ACC_W-1:0]   o_re,
    output logic [cmm_pkg::ACC_W-1:0]   o_im
);
    import cmm_pkg::*;

    t_ctl r_ctl1;
    t_ctl r_ctl2;
    logic signed [ACC_W-1:0] r_p_rr, r_p_ii, r_p_ri, r_p_ir;
    logic signed [ACC_W-1:0] n_p_rr, n_p_ii, n_p_ri, n_p_ir;
    logic [ACC_W-1:0] r_acc_re, r_acc_im;
    logic [ACC_W-1:0] n_acc_re, n_acc_im;
    logic [ACC_W-1:0] term_re, term_im;
    logic r_done;
    logic r_last;

    always_comb begin
        n_p_rr = $signed(i_a[HALF_W-1:0])      * $signed(i_b[HALF_W-1:0]);
        n_p_ii = $signed(i_a[ELEM_W-1:HALF_W]) * $signed(i_b[ELEM_W-1:HALF_W]);
        n_p_ri = $signed(i_a[HALF_W-1:0])      * $signed(i_b[ELEM_W-1:HALF_W]);
        n_p_ir = $signed(i_b[HALF_W-1:0])      * $signed(i_a[ELEM_W-1:HALF_W]);
    end

    assign term_re = ACC_W'(r_p_rr) - ACC_W'(r_p_ii);
    assign term_im = ACC_W'(r_p_ri) + ACC_W'(r_p_ir);

    always_comb begin
        n_acc_re = r_acc_re;
        n_acc_im = r_acc_im;
        if (r_ctl2.vld) begin
            if (r_ctl2.first) begin
                n_acc_re = term_re;
                n_acc_im = term_im;
            end else begin
                n_acc_re = r_acc_re + term_re;
                n_acc_im = r_acc_im + term_im;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
            r_done <= 1'b0;
            r_last <= 1'b0;
        end else begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
            r_done <= r_ctl2.vld && r_ctl2.fin;
            r_last <= r_ctl2.vld && r_ctl2.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_rr   <= n_p_rr;
        r_p_ii   <= n_p_ii;
        r_p_ri   <= n_p_ri;
        r_p_ir   <= n_p_ir;
        r_acc_re <= n_acc_re;
        r_acc_im <= n_acc_im;
    end

    assign o_done = r_done;
    assign o_last = r_last;
    assign o_re   = r_acc_re;
    assign o_im   = r_acc_im;

endmodule

// File: hdl/cmm_ctrl.sv
// Sequencer: side register, load counter, and row/column/inner index walk.
module cmm_ctrl #(
    parameter int MAX_DIM = 8,
    localparam int DEPTH = MAX_DIM * MAX_DIM,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [cmm_pkg::DIM_W-1:0]   i_cfg_dim,
    input  logic                        i_valid,
    output logic                        o_stall,
    output logic                        o_we,
    output logic [AW-1:0]               o_waddr,
    output logic [AW-1:0]               o_raddr_a,
    output logic [AW-1:0]               o_raddr_b,
    output cmm_pkg::t_ctl               o_ctl,
    input  logic                        i_res_done,
    input  logic                        i_res_last,
    input  logic                        i_out_free
);
    import cmm_pkg::*;

    localparam int SW = $clog2(MAX_DIM + 1);
    localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_state r_state, n_state;
    logic [DIM_W-1:0] r_dim, n_dim;
    logic [CW-1:0] r_load_cnt, n_load_cnt;
    logic [IW-1:0] r_i, n_i, r_j, n_j, r_z, n_z;
    logic [AW-1:0] r_row, n_row, r_a_addr, n_a_addr, r_b_addr, n_b_addr;

    logic [SW-1:0] side;
    logic [SW-1:0] side_m1;
    logic [AW-1:0] side_a;
    logic [CW-1:0] total;
    logic [CW-1:0] load_next;
    logic z_end, j_end, i_end;

    always_comb begin
        if (r_dim == '0) begin
            side = SW'(1);
        end else if (r_dim > DIM_W'(MAX_DIM)) begin
            side = SW'(MAX_DIM);
        end else begin
            side = r_dim[SW-1:0];
        end
    end

    assign side_m1   = side - SW'(1);
    assign side_a    = AW'(side);
    assign total     = CW'(side) * CW'(side);
    assign load_next = r_load_cnt + CW'(1);
    assign z_end     = (r_z == side_m1[IW-1:0]);
    assign j_end     = (r_j == side_m1[IW-1:0]);
    assign i_end     = (r_i == side_m1[IW-1:0]);

    always_comb begin
        n_state    = r_state;
        n_dim      = r_dim;
        n_load_cnt = r_load_cnt;
        n_i        = r_i;
        n_j        = r_j;
        n_z        = r_z;
        n_row      = r_row;
        n_a_addr   = r_a_addr;
        n_b_addr   = r_b_addr;
        unique case (r_state)
            S_LOAD: begin
                if (i_cfg_valid) begin
                    n_dim      = i_cfg_dim;
                    n_load_cnt = '0;
                end else if (i_valid) begin
                    if (load_next == total) begin
                        n_load_cnt = '0;
                        n_state    = S_HOLD;
                        n_i        = '0;
                        n_j        = '0;
                        n_z        = '0;
                        n_row      = '0;
                        n_a_addr   = '0;
                        n_b_addr   = '0;
                    end else begin
                        n_load_cnt = load_next;
                    end
                end
            end
            S_HOLD: begin
                if (i_out_free) begin
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                if (!z_end) begin
                    n_z      = r_z + IW'(1);
                    n_a_addr = r_a_addr + AW'(1);
                    n_b_addr = r_b_addr + side_a;
                end else begin
                    n_z     = '0;
                    n_state = S_DRAIN;
                    if (j_end) begin
                        n_j      = '0;
                        n_i      = r_i + IW'(1);
                        n_row    = r_row + side_a;
                        n_a_addr = r_row + side_a;
                        n_b_addr = '0;
                    end else begin
                        n_j      = r_j + IW'(1);
                        n_a_addr = r_row;
                        n_b_addr = AW'(r_j) + AW'(1);
                    end
                end
            end
            S_DRAIN: begin
                if (i_res_done) begin
                    n_state = i_res_last ? S_LOAD : S_HOLD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_dim      <= DIM_W'(DIM_RESET);
            r_load_cnt <= '0;
            r_i        <= '0;
            r_j        <= '0;
            r_z        <= '0;
            r_row      <= '0;
            r_a_addr   <= '0;
            r_b_addr   <= '0;
        end else begin
            r_state    <= n_state;
            r_dim      <= n_dim;
            r_load_cnt <= n_load_cnt;
            r_i        <= n_i;
            r_j        <= n_j;
            r_z        <= n_z;
            r_row      <= n_row;
            r_a_addr   <= n_a_addr;
            r_b_addr   <= n_b_addr;
        end
    end

    assign o_cfg_ready = (r_state == S_LOAD);
    assign o_stall     = (r_state != S_LOAD) || i_cfg_valid;
    assign o_we        = i_valid && !o_stall;
    assign o_waddr     = r_load_cnt[AW-1:0];
    assign o_raddr_a   = r_a_addr;
    assign o_raddr_b   = r_b_addr;

    always_comb begin
        o_ctl.vld   = (r_state == S_ISSUE);
        o_ctl.first = (r_z == '0);
        o_ctl.fin   = z_end;
        o_ctl.last  = z_end && j_end && i_end;
    end

endmodule

// File: bench/testbench.sv
// Self-checking testbench for the complex matrix multiply unit.
module testbench;
    import cmm_pkg::*;

    localparam int MAX_SIDE     = 8;
    localparam int STORE_DEPTH  = MAX_SIDE * MAX_SIDE;
    localparam int KEEP_DIM     = -1;
    localparam int RESET_CYCLES = 8;
    localparam int SETTLE       = 16;
    localparam int TAIL         = 40;
    localparam int LONG_HOLD    = 600;
    localparam int STALL_LIMIT  = 5000;

    typedef struct packed {
        logic signed [HALF_W-1:0] re;
        logic signed [HALF_W-1:0] im;
    } t_cplx;

    typedef struct {
        t_cplx a;
        t_cplx b;
    } t_operand;

    typedef struct {
        logic signed [ACC_W-1:0] re;
        logic signed [ACC_W-1:0] im;
        logic                    last;
    } t_product;

    typedef struct {
        int                      new_dim;
        logic signed [HALF_W-1:0] a_re;
        logic signed [HALF_W-1:0] a_im;
        logic signed [HALF_W-1:0] b_re;
        logic signed [HALF_W-1:0] b_im;
        bit                      typed;
        logic signed [ACC_W-1:0] d_re;
        logic signed [ACC_W-1:0] d_im;
    } t_script_row;

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [DIM_W-1:0]          i_cfg_dim   = '0;
    logic                      i_valid     = 1'b0;
    logic                      o_stall;
    logic signed [HALF_W-1:0]  i_a_re      = '0;
    logic signed [HALF_W-1:0]  i_a_im      = '0;
    logic signed [HALF_W-1:0]  i_b_re      = '0;
    logic signed [HALF_W-1:0]  i_b_im      = '0;
    logic                      o_valid;
    logic                      i_stall     = 1'b0;
    logic signed [ACC_W-1:0]   o_d_re;
    logic signed [ACC_W-1:0]   o_d_im;
    logic                      o_last;

    t_cplx            left_mem  [STORE_DEPTH];
    t_cplx            right_mem [STORE_DEPTH];
    logic [DIM_W-1:0] side_reg = DIM_RESET[DIM_W-1:0];
    int               fill     = 0;
    t_product         matrix_out_q [$];
    t_product         product_q [$];
    t_product         want;

    int          mismatches  = 0;
    int          burst_left  = 0;
    int          quiet_count = 0;
    bit          hold_arm    = 1'b0;
    bit          hold_done   = 1'b0;
    int          hold_left   = 0;
    logic [15:0] rx_tick     = '0;

    logic [DIM_W-1:0] phase_dim [13] = '{15, 3, 1, 2, 5, 0, 6, 2, 3, 4, 7, 1, 8};

    t_script_row script [26] = '{
        '{KEEP_DIM, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 0, 0, 0},
        '{KEEP_DIM, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 0, 0, 0},
        '{KEEP_DIM, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 0, 0, 0},
        '{KEEP_DIM, 16'sh0001, 16'shFFFF, 16'shFFFF, 16'sh0001, 0, 0, 0},
        '{KEEP_DIM, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0, 0, 0},
        '{KEEP_DIM, 16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh0001, 0, 0, 0},
        '{KEEP_DIM, 16'sh1234, 16'shEDCB, 16'sh0F0F, 16'shF0F0, 0, 0, 0},
        '{KEEP_DIM, 16'sh5555, 16'shAAAA, 16'shAAAA, 16'sh5555, 0, 0, 0},
        '{KEEP_DIM, 16'sh0000, 16'sh8000, 16'sh7FFF, 16'sh0000, 0, 0, 0},
        '{KEEP_DIM, 16'sh0001, 16'sh0000, 16'sh0000, 16'sh0001, 0, 0, 0},
        '{KEEP_DIM, 16'shFFFF, 16'shFFFF, 16'sh8000, 16'sh8000, 0, 0, 0},
        '{KEEP_DIM, 16'sh00FF, 16'shFF00, 16'sh7F80, 16'sh807F, 0, 0, 0},
        '{KEEP_DIM, 16'sh7FFF, 16'sh0000, 16'sh7FFF, 16'sh0000, 0, 0, 0},
        '{KEEP_DIM, 16'sh8000, 16'sh0000, 16'sh0000, 16'sh8000, 0, 0, 0},
        '{KEEP_DIM, 16'sh3C3C, 16'shC3C3, 16'sh6996, 16'sh9669, 0, 0, 0},
        '{KEEP_DIM, 16'sh0002, 16'shFFFE, 16'sh4000, 16'shC000, 0, 0, 0},
        '{1,        16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1,
          32'sh0000_0000, 32'sh8000_0000},
        '{KEEP_DIM, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1,
          32'sh0000_0000, 32'sh7FFE_0002},
        '{KEEP_DIM, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 1,
          32'sh0000_0000, 32'sh7FFF_0001},
        '{0,        16'sh0000, 16'sh0001, 16'sh0000, 16'sh0001, 1,
          32'shFFFF_FFFF, 32'sh0000_0000},
        '{2,        16'sh7FFF, 16'sh8000, 16'sh0001, 16'sh7FFF, 0, 0, 0},
        '{KEEP_DIM, 16'sh4321, 16'sh8765, 16'sh0FED, 16'shCBA9, 0, 0, 0},
        '{2,        16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh8000, 0, 0, 0},
        '{KEEP_DIM, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 0, 0, 0},
        '{KEEP_DIM, 16'shFFFF, 16'sh0001, 16'sh7FFF, 16'sh8000, 0, 0, 0},
        '{KEEP_DIM, 16'sh2468, 16'shDB97, 16'sh1357, 16'shECA9, 0, 0, 0}
    };

    complex_matrix_multiply_unit #(
        .MAX_DIM (MAX_SIDE)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_dim   (i_cfg_dim),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_a_re      (i_a_re),
        .i_a_im      (i_a_im),
        .i_b_re      (i_b_re),
        .i_b_im      (i_b_im),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_d_re      (o_d_re),
        .o_d_im      (o_d_im),
        .o_last      (o_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int side_of(logic [DIM_W-1:0] d);
        if (d == 0) begin
            return 1;
        end
        if (d > MAX_SIDE) begin
            return MAX_SIDE;
        end
        return int'(d);
    endfunction

    function automatic void absorb_element(t_operand op);
        int       n;
        int       acc_re;
        int       acc_im;
        t_cplx    x;
        t_cplx    y;
        t_product p;
        matrix_out_q.delete();
        n = side_of(side_reg);
        left_mem[fill]  = op.a;
        right_mem[fill] = op.b;
        fill++;
        if (fill < n * n) begin
            return;
        end
        fill = 0;
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                acc_re = 0;
                acc_im = 0;
                for (int z = 0; z < n; z++) begin
                    x = left_mem[i * n + z];
                    y = right_mem[z * n + j];
                    acc_re += int'($signed(x.re)) * int'($signed(y.re))
                            - int'($signed(x.im)) * int'($signed(y.im));
                    acc_im += int'($signed(x.re)) * int'($signed(y.im))
                            + int'($signed(y.re)) * int'($signed(x.im));
                end
                p.re   = acc_re;
                p.im   = acc_im;
                p.last = (i == n - 1) && (j == n - 1);
                matrix_out_q.push_back(p);
            end
        end
    endfunction

    function automatic logic signed [HALF_W-1:0] pick_half();
        case ($urandom_range(0, 9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            3:       return 16'shFFFF;
            4:       return 16'($urandom_range(0, 7));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_operand rand_operand();
        t_operand op;
        op.a.re = pick_half();
        op.a.im = pick_half();
        op.b.re = pick_half();
        op.b.im = pick_half();
        return op;
    endfunction

    task automatic send_operand(t_operand op, bit use_model);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        i_valid <= 1'b1;
        i_a_re  <= op.a.re;
        i_a_im  <= op.a.im;
        i_b_re  <= op.b.re;
        i_b_im  <= op.b.im;
        do @(posedge i_clk); while (o_stall);
        burst_left--;
        absorb_element(op);
        if (use_model) begin
            foreach (matrix_out_q[k]) product_q.push_back(matrix_out_q[k]);
        end
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (product_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_dim(logic [DIM_W-1:0] d);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_dim   <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        side_reg = d;
        fill     = 0;
    endtask

    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 16'd1;
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (hold_arm && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= LONG_HOLD;
            i_stall   <= 1'b1;
        end else begin
            case (rx_tick[8:6])
                3'd0, 3'd1: i_stall <= 1'b0;
                3'd2:       i_stall <= ($urandom_range(0, 1) == 1);
                3'd3:       i_stall <= (rx_tick[2:0] == 3'd0);
                3'd4:       i_stall <= ($urandom_range(0, 3) != 0);
                3'd5:       i_stall <= rx_tick[3];
                default:    i_stall <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (product_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected beat: re %0d im %0d last %0b",
                         $time, o_d_re, o_d_im, o_last);
            end else begin
                want = product_q.pop_front();
                if (o_d_re !== want.re) begin
                    mismatches++;
                    $display("%0t: d_re expected %0d actual %0d", $time, want.re, o_d_re);
                end
                if (o_d_im !== want.im) begin
                    mismatches++;
                    $display("%0t: d_im expected %0d actual %0d", $time, want.im, o_d_im);
                end
                if (o_last !== want.last) begin
                    mismatches++;
                    $display("%0t: last expected %0b actual %0b", $time, want.last, o_last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_count <= 0;
        end else begin
            quiet_count <= quiet_count + 1;
        end
        if (quiet_count == STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        t_operand op;
        t_product typed_res;
        int       n;
        int       reps;
        int       partial;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[r]) begin
            if (script[r].new_dim != KEEP_DIM) begin
                write_dim(DIM_W'(script[r].new_dim));
            end
            op.a.re = script[r].a_re;
            op.a.im = script[r].a_im;
            op.b.re = script[r].b_re;
            op.b.im = script[r].b_im;
            send_operand(op, !script[r].typed);
            if (script[r].typed) begin
                typed_res.re   = script[r].d_re;
                typed_res.im   = script[r].d_im;
                typed_res.last = 1'b1;
                product_q.push_back(typed_res);
            end
        end

        foreach (phase_dim[p]) begin
            write_dim(phase_dim[p]);
            n = side_of(phase_dim[p]);
            reps = (n * n >= 16) ? 1 : 24 / (n * n);
            if (reps > 1) begin
                hold_arm <= 1'b1;
            end
            if (n > 1 && $urandom_range(0, 2) == 0) begin
                partial = $urandom_range(1, n * n - 1);
                repeat (partial) send_operand(rand_operand(), 1'b1);
                write_dim(phase_dim[p]);
            end
            repeat (reps * n * n) send_operand(rand_operand(), 1'b1);
        end

        wait_idle();
        repeat (TAIL) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: complex_matrix_multiply_unit.f
hdl/cmm_pkg.sv
hdl/cmm_store.sv
hdl/cmm_mac.sv
hdl/cmm_ctrl.sv
hdl/complex_matrix_multiply_unit.sv
bench/testbench.sv
